[src/tph_pkg.sv]
// Shared types and constants for the tag presence hold timer.
// No dependencies; imported by every module of the block.
package tph_pkg;

    localparam int UID_FIELD_BYTES = 7;
    localparam int UID_FIELD_W     = 8 * UID_FIELD_BYTES;
    localparam int LEN_W           = 3;
    localparam int CNT_W           = 16;
    localparam int FT_W            = 16;
    localparam int UID_BYTES_DEF   = 7;

    localparam logic [CNT_W-1:0] HOLD_RESET = 16'd5000;
    localparam logic [FT_W-1:0]  FT_RESET   = 16'd0;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index, taken from paddr[2]
    localparam logic REG_HOLD_TICKS = 1'b0;
    localparam logic REG_FRAME_TYPE = 1'b1;

    // input word kinds
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] hold_ticks;
        logic [FT_W-1:0]  frame_type;
    } cfg_t;

    typedef struct packed {
        logic                   event_valid;
        logic                   event_placed;
        logic [UID_FIELD_W-1:0] event_uid;
        logic [FT_W-1:0]        event_frame_type;
        logic                   green_led;
        logic                   red_led;
    } result_t;

endpackage

[src/tag_presence_hold_timer.sv]
// Tag presence hold timer: the result word is registered in the output buffer;
// one word per cycle while the buffer has room; each input word gives exactly
// one result word. Input accepted while a result waits, via a two-entry output
// buffer; it stalls only when both result and skid entries are full.
// Reset (aresetn, synchronous, active low) clears presence, stored UIDs, the hold
// state and the buffer; hold_ticks returns to 5000 and frame_type to 0.
module tag_presence_hold_timer #(
    parameter int UID_BYTES = tph_pkg::UID_BYTES_DEF   // stored UID bytes, 4..7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,   // card_present[0], uid_bytes[56:1],
                                                  // uid_len[59:57], zero[63:60]
    input  logic                       s_tuser,   // kind
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata,   // event_placed[0], event_uid[56:1],
                                                  // event_frame_type[72:57],
                                                  // green_led[73], red_led[74], zero[79:75]
    output logic                       m_tuser,   // event_valid
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tph_pkg::APB_AW-1:0] paddr,
    input  logic [tph_pkg::APB_DW-1:0] pwdata,
    output logic [tph_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import tph_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    logic    in_fire;
    logic    buf_ready;

    // Unpack the input word
    logic                   card_present;
    logic [UID_FIELD_W-1:0] uid_bytes;
    logic [LEN_W-1:0]       uid_len;

    assign card_present = s_tdata[0];
    assign uid_bytes    = s_tdata[UID_FIELD_W:1];
    assign uid_len      = s_tdata[UID_FIELD_W+LEN_W:UID_FIELD_W+1];

    // A word is taken whenever the buffer has room; the core updates its
    // state on the same edge the result is written into the buffer.
    assign s_tready = buf_ready;
    assign in_fire  = s_tvalid && s_tready;

    tph_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tph_core #(
        .UID_BYTES (UID_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .kind         (s_tuser),
        .card_present (card_present),
        .uid_bytes    (uid_bytes),
        .uid_len      (uid_len),
        .cfg          (cfg),
        .res          (core_res)
    );

    tph_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (buf_ready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result word, first field lowest
    always_comb begin
        m_tdata                                    = '0;
        m_tdata[0]                                 = out_res.event_placed;
        m_tdata[UID_FIELD_W:1]                     = out_res.event_uid;
        m_tdata[UID_FIELD_W+FT_W:UID_FIELD_W+1]    = out_res.event_frame_type;
        m_tdata[UID_FIELD_W+FT_W+1]                = out_res.green_led;
        m_tdata[UID_FIELD_W+FT_W+2]                = out_res.red_led;
    end
    assign m_tuser = out_res.event_valid;

endmodule

[src/tph_regs.sv]
// APB configuration registers: hold time and frame type.
// Depends on tph_pkg.
module tph_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tph_pkg::APB_AW-1:0] paddr,
    input  logic [tph_pkg::APB_DW-1:0] pwdata,
    output logic [tph_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output tph_pkg::cfg_t              cfg
);
    import tph_pkg::*;

    logic [CNT_W-1:0] hold_ticks_reg;
    logic [FT_W-1:0]  frame_type_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= HOLD_RESET;
            frame_type_reg <= FT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HOLD_TICKS: hold_ticks_reg <= pwdata[CNT_W-1:0];
                REG_FRAME_TYPE: frame_type_reg <= pwdata[FT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_HOLD_TICKS: prdata[CNT_W-1:0] = hold_ticks_reg;
            REG_FRAME_TYPE: prdata[FT_W-1:0]  = frame_type_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.hold_ticks = hold_ticks_reg;
    assign cfg.frame_type = frame_type_reg;

endmodule

[src/tph_core.sv]
// Presence tracking, UID compare and hold counter; one word per cycle while in_fire is high.
// Depends on tph_pkg. Result is formed combinationally from the state.
module tph_core #(
    parameter int UID_BYTES = tph_pkg::UID_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_fire,
    input  logic                            kind,
    input  logic                            card_present,
    input  logic [tph_pkg::UID_FIELD_W-1:0] uid_bytes,
    input  logic [tph_pkg::LEN_W-1:0]       uid_len,
    input  tph_pkg::cfg_t                   cfg,
    output tph_pkg::result_t                res
);
    import tph_pkg::*;

    localparam int UID_W = 8 * UID_BYTES;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(UID_BYTES);
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    logic             tag_present_reg, tag_present_next;
    logic [UID_W-1:0] last_uid_reg, last_uid_next;
    logic [LEN_W-1:0] last_len_reg, last_len_next;
    logic             holding_reg, holding_next;
    logic [UID_W-1:0] held_uid_reg, held_uid_next;
    logic [CNT_W-1:0] hold_count_reg, hold_count_next;

    logic [LEN_W-1:0]       len_c;
    logic [UID_FIELD_W-1:0] uid_m;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   is_new;
    logic                   ev_valid;
    logic                   ev_placed;
    logic [UID_FIELD_W-1:0] ev_uid;

    // clip length, zero bytes past it
    always_comb begin
        len_c = (uid_len > LEN_MAX) ? LEN_MAX : uid_len;
        for (int i = 0; i < UID_FIELD_BYTES; i++) begin
            uid_m[8*i +: 8] = (LEN_W'(i) < len_c) ? uid_bytes[8*i +: 8] : 8'h00;
        end
    end

    assign is_new  = !tag_present_reg || (len_c != last_len_reg) ||
                     (uid_m[UID_W-1:0] != last_uid_reg);
    assign cnt_inc = (hold_count_reg != CNT_SAT) ? hold_count_reg + 1'b1 : hold_count_reg;

    always_comb begin
        tag_present_next = tag_present_reg;
        last_uid_next    = last_uid_reg;
        last_len_next    = last_len_reg;
        holding_next     = holding_reg;
        held_uid_next    = held_uid_reg;
        hold_count_next  = hold_count_reg;
        ev_valid         = 1'b0;
        ev_placed        = 1'b0;
        ev_uid           = '0;
        case (kind)
            KIND_POLL: begin
                if (card_present) begin
                    if (is_new) begin
                        last_uid_next    = uid_m[UID_W-1:0];
                        last_len_next    = len_c;
                        tag_present_next = 1'b1;
                        if (!holding_reg) begin
                            held_uid_next   = uid_m[UID_W-1:0];
                            hold_count_next = '0;
                            holding_next    = 1'b1;
                            ev_valid        = 1'b1;
                            ev_placed       = 1'b1;
                            ev_uid          = uid_m;
                        end
                    end
                end else begin
                    tag_present_next = 1'b0;
                end
            end
            KIND_TICK: begin
                if (holding_reg) begin
                    hold_count_next = cnt_inc;
                    if (cnt_inc >= cfg.hold_ticks) begin
                        // held UID was already masked when latched
                        holding_next         = 1'b0;
                        ev_valid             = 1'b1;
                        ev_uid[UID_W-1:0]    = held_uid_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_present_reg <= 1'b0;
            last_uid_reg    <= '0;
            last_len_reg    <= '0;
            holding_reg     <= 1'b0;
            held_uid_reg    <= '0;
            hold_count_reg  <= '0;
        end else if (in_fire) begin
            tag_present_reg <= tag_present_next;
            last_uid_reg    <= last_uid_next;
            last_len_reg    <= last_len_next;
            holding_reg     <= holding_next;
            held_uid_reg    <= held_uid_next;
            hold_count_reg  <= hold_count_next;
        end
    end

    assign res.event_valid      = ev_valid;
    assign res.event_placed     = ev_placed;
    assign res.event_uid        = ev_uid;
    assign res.event_frame_type = ev_valid ? cfg.frame_type : '0;
    assign res.green_led        = tag_present_next;
    assign res.red_led          = !tag_present_next;

`ifndef NO_ASSERTIONS
    a_placed_starts_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && ev_valid && ev_placed) |=> (holding_reg && hold_count_reg == '0))
        else $error("placed word did not start the hold");
    a_removed_ends_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && ev_valid && !ev_placed) |=> !holding_reg)
        else $error("removed word left the hold running");
    a_placed_needs_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid && ev_placed) |-> (!holding_reg && card_present))
        else $error("placed word while a hold runs");
`endif

endmodule

[src/tph_out_buf.sv]
// Two-entry output buffer (result register plus skid) for the result channel.
// Depends on tph_pkg.
module tph_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tph_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tph_pkg::result_t out_data
);
    import tph_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    main_reg       <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_reg       <= in_data;
                    main_valid_reg <= push;
                end
            end else if (push) begin
                if (!main_valid_reg) begin
                    main_reg       <= in_data;
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= in_data;
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");
    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("word pushed into a stalled buffer was dropped");
`endif

endmodule

[tb/sv/tb_tag_presence_hold_timer.sv]
// Self-checking bench for tag_presence_hold_timer: stream-in polls and ticks,
// predict each result word in-bench, compare every field as results arrive.
// Depends on tph_pkg (widths, kind and register codes, result_t) and the DUT.
module tb_tag_presence_hold_timer;
    import tph_pkg::*;

    // one input word as the bench sees it, plus the sender's pre-gap
    typedef struct {
        logic                   kind;
        logic                   card_present;
        logic [UID_FIELD_W-1:0] uid_bytes;
        logic [LEN_W-1:0]       uid_len;
        int                     gap;
    } word_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata  = '0;   // card_present[0], uid_bytes[56:1], uid_len[59:57]
    logic              s_tuser  = 1'b0; // kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [79:0]       m_tdata;         // event_placed[0], event_uid[56:1],
                                        // event_frame_type[72:57], green_led[73], red_led[74]
    logic              m_tuser;         // event_valid
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // stimulus and expectation stores
    word_t   pending[$];
    result_t events_due[$];
    word_t   tx_word;
    int      tx_wait       = 0;
    int      rx_wait       = 0;
    int      rx_count      = 0;
    int      words_queued  = 0;
    int      words_checked = 0;
    int      fails         = 0;
    bit      tx_idle       = 1'b1;
    bit      rx_idle       = 1'b1;
    bit      rx_allow      = 1'b1;  // off during long tick bursts to keep the run short
    bit      hold_off_req  = 1'b0;  // asks the receiver for one long stall
    result_t due;

    // last fresh card the random part produced, so it can be polled again
    logic [UID_FIELD_W-1:0] recent_uid = '0;
    logic [LEN_W-1:0]       recent_len = '0;

    // predictor state: presence, last card seen, running hold
    logic                   tag_seen  = 1'b0;
    logic [UID_FIELD_W-1:0] seen_uid  = '0;
    logic [LEN_W-1:0]       seen_len  = '0;
    logic                   hold_on   = 1'b0;
    logic [UID_FIELD_W-1:0] hold_uid  = '0;   // kept already masked to its length
    logic [CNT_W-1:0]       hold_cnt  = '0;
    logic [CNT_W-1:0]       cfg_hold  = HOLD_RESET;
    logic [FT_W-1:0]        cfg_ftype = FT_RESET;

    tag_presence_hold_timer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Works out the result word for one accepted input word and advances
    // the tracked presence / hold state.
    function automatic result_t track_tag(word_t w);
        result_t                r;
        logic [LEN_W-1:0]       n;
        logic [UID_FIELD_W-1:0] uid;
        r = '0;
        if (w.kind == KIND_POLL) begin
            if (w.card_present) begin
                n = w.uid_len;
                if (n > UID_BYTES_DEF) n = LEN_W'(UID_BYTES_DEF);
                // bytes past the length read as zero
                uid = '0;
                for (int b = 0; b < n; b++) uid[8*b +: 8] = w.uid_bytes[8*b +: 8];
                if (!tag_seen || n != seen_len || uid != seen_uid) begin
                    seen_uid = uid;
                    seen_len = n;
                    tag_seen = 1'b1;
                    // a changed card only opens a hold when none is running
                    if (!hold_on) begin
                        hold_uid = uid;
                        hold_cnt = '0;
                        hold_on  = 1'b1;
                        r.event_valid  = 1'b1;
                        r.event_placed = 1'b1;
                        r.event_uid    = uid;
                    end
                end
            end else begin
                // card gone: LEDs flip, hold keeps counting
                tag_seen = 1'b0;
            end
        end else if (hold_on) begin
            if (hold_cnt != '1) hold_cnt++;
            if (hold_cnt >= cfg_hold) begin
                hold_on = 1'b0;
                r.event_valid = 1'b1;
                r.event_uid   = hold_uid;
            end
        end
        if (r.event_valid) r.event_frame_type = cfg_ftype;
        r.green_led = tag_seen;
        r.red_led   = !tag_seen;
        return r;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // Driver: presents queued words, each after its own gap; the prediction
    // is taken at the edge where the word is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) events_due.push_back(track_tag(tx_word));
            if (pending.size() != 0 && tx_wait >= pending[0].gap) begin
                tx_word = pending.pop_front();
                s_tdata  <= {4'b0, tx_word.uid_len, tx_word.uid_bytes, tx_word.card_present};
                s_tuser  <= tx_word.kind;
                s_tvalid <= 1'b1;
                tx_wait = 0;
            end else begin
                s_tvalid <= 1'b0;
                if (pending.size() != 0) tx_wait++;
            end
        end
    end

    // Monitor: checks every result word, then draws its own stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    fails++;
                    $display("%0t: result word with none expected, actual %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    due = events_due.pop_front();
                    check_field("event_valid", due.event_valid, m_tuser);
                    check_field("event_placed", due.event_placed, m_tdata[0]);
                    check_field("event_uid", due.event_uid, m_tdata[56:1]);
                    check_field("event_frame_type", due.event_frame_type, m_tdata[72:57]);
                    check_field("green_led", due.green_led, m_tdata[73]);
                    check_field("red_led", due.red_led, m_tdata[74]);
                    words_checked++;
                end
                rx_count++;
                if (rx_count % 40 == 0) rx_idle = ($urandom_range(0, 3) != 0);
                rx_wait = (rx_allow && rx_idle) ? $urandom_range(0, 9) : 0;
            end
            // long hold-off: input side runs into a full buffer and stalls
            if (hold_off_req && rx_wait == 0) begin
                rx_wait = 400;
                hold_off_req = 1'b0;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic kind, logic present, logic [UID_FIELD_W-1:0] bytes,
                             logic [LEN_W-1:0] len);
        word_t w;
        w.kind         = kind;
        w.card_present = present;
        w.uid_bytes    = bytes;
        w.uid_len      = len;
        w.gap          = tx_idle ? $urandom_range(0, 9) : 0;
        pending.push_back(w);
        words_queued++;
    endtask

    // Register write, then read back over the same port.
    task automatic cfg_write(logic idx, logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};   // upper half is not part of the register
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_HOLD_TICKS) cfg_hold = value;
        else cfg_ftype = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("prdata", value, prdata[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly card sessions: fresh cards, the same card polled again (junk in
    // the bytes past its length), length changes, removals and ticks.
    task automatic random_items(int count, bit idle_ok);
        logic [UID_FIELD_W-1:0] bytes;
        logic [LEN_W-1:0]       len;
        int                     pick;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) tx_idle = idle_ok && ($urandom_range(0, 3) != 0);
            pick  = $urandom_range(0, 99);
            bytes = UID_FIELD_W'({$urandom, $urandom});
            len   = LEN_W'($urandom_range(0, 7));
            if (pick < 45) begin
                send_word(KIND_TICK, 1'($urandom_range(0, 1)), bytes, len);
            end else if (pick < 55) begin
                send_word(KIND_POLL, 1'b0, bytes, len);
            end else begin
                if (pick < 80) begin
                    // same card, or same prefix at another length
                    if (pick >= 74) recent_len = len;
                    for (int b = 0; b < recent_len; b++) bytes[8*b +: 8] = recent_uid[8*b +: 8];
                    len = recent_len;
                end else begin
                    recent_uid = bytes;
                    recent_len = len;
                end
                send_word(KIND_POLL, 1'b1, bytes, len);
            end
        end
    endtask

    // Wait until every expected word is back, plus a margin.
    task automatic settle();
        while (words_checked != words_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, with reset register values (hold 5000, frame type 0)
        tx_idle = 1'b1;
        send_word(KIND_TICK, 1'b1, '1, 3'd7);                     // tick, no hold yet
        send_word(KIND_POLL, 1'b0, 56'h12_3456_789A_BCDE, 3'd7);  // no card
        send_word(KIND_POLL, 1'b1, 56'hA5_0102_0304_0506, 3'd7);  // placed
        send_word(KIND_POLL, 1'b1, 56'hA5_0102_0304_0506, 3'd7);  // same card
        send_word(KIND_POLL, 1'b1, 56'hFF_FFFF_FFFF_FFFF, 3'd7);  // new card during hold
        send_word(KIND_POLL, 1'b1, 56'hFF_FFFF_FFFF_FFFF, 3'd3);  // length change
        send_word(KIND_POLL, 1'b1, 56'h12_3456_78FF_FFFF, 3'd3);  // junk past length only
        send_word(KIND_POLL, 1'b1, 56'h00_0000_0000_0000, 3'd0);  // empty UID
        send_word(KIND_POLL, 1'b1, 56'hFF_FFFF_FFFF_FFFF, 3'd0);  // empty UID again
        send_word(KIND_POLL, 1'b0, '0, 3'd0);                     // card removed
        tx_idle = 1'b0;
        repeat (20) send_word(KIND_TICK, 1'b0, '0, 3'd0);        // well short of reset hold
        tx_idle = 1'b1;
        send_word(KIND_POLL, 1'b1, '0, 3'd0);                     // empty card, hold still on
        send_word(KIND_POLL, 1'b1, '1, 3'd0);                     // still the same
        send_word(KIND_POLL, 1'b0, '1, 3'd7);
        settle();

        // hold of 1, all-ones frame type
        cfg_write(REG_HOLD_TICKS, 16'd1);
        cfg_write(REG_FRAME_TYPE, 16'hFFFF);
        random_items(300, 1'b1);
        settle();

        // zero hold: first tick ends it
        cfg_write(REG_HOLD_TICKS, 16'd0);
        cfg_write(REG_FRAME_TYPE, 16'h0000);
        random_items(200, 1'b1);
        settle();

        // back-pressure: sender streams without gaps into a stalled receiver
        cfg_write(REG_HOLD_TICKS, 16'($urandom_range(2, 20)));
        cfg_write(REG_FRAME_TYPE, 16'($urandom_range(0, 65535)));
        hold_off_req = 1'b1;
        random_items(200, 1'b0);
        settle();

        for (int p = 0; p < 4; p++) begin
            cfg_write(REG_HOLD_TICKS, 16'($urandom_range(2, (p == 3) ? 300 : 40)));
            cfg_write(REG_FRAME_TYPE, 16'($urandom_range(0, 65535)));
            random_items(250, 1'b1);
            settle();
        end

        // clear any hold still running, then the longest hold
        cfg_write(REG_HOLD_TICKS, 16'd1);
        tx_idle = 1'b0;
        send_word(KIND_TICK, 1'b0, '0, 3'd0);
        settle();
        cfg_write(REG_HOLD_TICKS, 16'hFFFF);
        cfg_write(REG_FRAME_TYPE, 16'h8001);
        rx_allow = 1'b0;
        send_word(KIND_POLL, 1'b0, '0, 3'd0);
        send_word(KIND_POLL, 1'b1, UID_FIELD_W'({$urandom, $urandom}), 3'd7);
        repeat (20) send_word(KIND_TICK, 1'b1, '1, 3'd7);        // hold keeps running
        send_word(KIND_POLL, 1'b1, UID_FIELD_W'({$urandom, $urandom}), 3'd5);
        settle();

        repeat (20) @(posedge aclk);
        if (fails == 0 && events_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(8 * 1000000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
